// File: src/frct_pkg.sv
// Shared types and constants for the frame reference-count table.
`timescale 1ns / 1ps

package frct_pkg;

    localparam int DEF_DEPTH  = 64;
    localparam int DEF_ADDR_W = 48;
    localparam int COUNT_W    = 16;
    localparam int LIVE_W     = 7;
    localparam int STAT_W     = 32;
    localparam int STATUS_W   = 3;
    localparam int M_TDATA_W  = 208;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    typedef enum logic [STATUS_W-1:0] {
        ST_IGNORED     = 3'd0,
        ST_INCREMENTED = 3'd1,
        ST_INSERTED    = 3'd2,
        ST_DROPPED     = 3'd3,
        ST_DECREMENTED = 3'd4,
        ST_FREED       = 3'd5,
        ST_UNTRACKED   = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_FIN,
        FSM_OUT
    } fsm_t;

    typedef struct packed {
        logic shift;
        logic load;
    } ring_ctrl_t;

    typedef struct packed {
        logic [STAT_W-1:0]   max_count;
        logic [STAT_W-1:0]   inserts;
        logic [STAT_W-1:0]   untracked;
        logic [STAT_W-1:0]   drops;
        logic [STAT_W-1:0]   releases;
        logic [STAT_W-1:0]   acquires;
        logic [LIVE_W-1:0]   live;
        logic [COUNT_W-1:0]  count_after;
        status_t             status;
    } result_t;

endpackage

// File: src/frct_cell.sv
// One table slot of the rotating ring: address and sharing count.
`timescale 1ns / 1ps

module frct_cell #(
    parameter int ADDR_W = frct_pkg::DEF_ADDR_W,
    parameter int IDX_W  = 6,
    parameter int INDEX  = 0
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  frct_pkg::ring_ctrl_t        ctl,
    input  logic [IDX_W-1:0]            load_idx,
    input  logic [ADDR_W-1:0]           nxt_addr,
    input  logic [frct_pkg::COUNT_W-1:0] nxt_count,
    input  logic [ADDR_W-1:0]           load_addr,
    input  logic [frct_pkg::COUNT_W-1:0] load_count,
    output logic [ADDR_W-1:0]           addr,
    output logic [frct_pkg::COUNT_W-1:0] count
);

    logic [ADDR_W-1:0]            addr_reg;
    logic [frct_pkg::COUNT_W-1:0] count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg  <= '0;
            count_reg <= '0;
        end else if (ctl.shift) begin
            addr_reg  <= nxt_addr;
            count_reg <= nxt_count;
        end else if (ctl.load && load_idx == IDX_W'(INDEX)) begin
            addr_reg  <= load_addr;
            count_reg <= load_count;
        end
    end

    assign addr  = addr_reg;
    assign count = count_reg;

endmodule

// File: src/frct_ctrl.sv
// Scan controller at the head of the ring, with the statistics counters.
`timescale 1ns / 1ps

module frct_ctrl #(
    parameter int DEPTH  = frct_pkg::DEF_DEPTH,
    parameter int ADDR_W = frct_pkg::DEF_ADDR_W,
    parameter int IDX_W  = 6
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic                         req_action,
    input  logic [ADDR_W-1:0]            req_addr,
    input  logic                         out_free,
    input  logic [ADDR_W-1:0]            head_addr,
    input  logic [frct_pkg::COUNT_W-1:0] head_count,
    output frct_pkg::ring_ctrl_t         ring,
    output logic [IDX_W-1:0]             load_idx,
    output logic [ADDR_W-1:0]            tail_addr,
    output logic [frct_pkg::COUNT_W-1:0] tail_count,
    output logic                         idle,
    output logic                         res_valid,
    output frct_pkg::result_t            res
);

    localparam int LCNT_W = $clog2(DEPTH + 1);

    frct_pkg::fsm_t                  state_reg, state_next;
    logic [IDX_W-1:0]                cnt_reg;
    logic                            action_reg;
    logic [ADDR_W-1:0]               addr_reg;
    logic                            found_reg;
    logic                            have_empty_reg;
    logic [IDX_W-1:0]                empty_idx_reg;
    frct_pkg::status_t               status_reg;
    logic [frct_pkg::COUNT_W-1:0]    count_reg;
    logic [LCNT_W-1:0]               live_reg;
    logic [frct_pkg::STAT_W-1:0]     acq_reg, rel_reg, drop_reg, untr_reg, ins_reg;
    logic [frct_pkg::COUNT_W-1:0]    peak_reg;

    logic                            hit;
    logic [frct_pkg::COUNT_W-1:0]    inc_count, dec_count;
    frct_pkg::status_t               fin_status;
    logic [frct_pkg::COUNT_W-1:0]    fin_count;
    logic [LCNT_W+frct_pkg::LIVE_W-1:0] live_ext;

    assign hit       = !found_reg && head_addr == addr_reg;
    assign inc_count = (head_count == frct_pkg::COUNT_MAX) ? head_count
                                                          : head_count + 1'b1;
    // A tracked slot holding zero stays at zero and is freed.
    assign dec_count = (head_count == '0) ? head_count : head_count - 1'b1;

    always_comb begin
        if (addr_reg == '0) begin
            fin_status = frct_pkg::ST_IGNORED;
        end else if (found_reg) begin
            fin_status = status_reg;
        end else if (action_reg) begin
            fin_status = frct_pkg::ST_UNTRACKED;
        end else if (have_empty_reg) begin
            fin_status = frct_pkg::ST_INSERTED;
        end else begin
            fin_status = frct_pkg::ST_DROPPED;
        end
    end

    always_comb begin
        if (fin_status == frct_pkg::ST_INSERTED) begin
            fin_count = frct_pkg::COUNT_W'(1);
        end else if (found_reg && addr_reg != '0) begin
            fin_count = count_reg;
        end else begin
            fin_count = '0;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            frct_pkg::FSM_IDLE: begin
                if (start) begin
                    state_next = (req_addr == '0) ? frct_pkg::FSM_FIN : frct_pkg::FSM_SCAN;
                end
            end
            frct_pkg::FSM_SCAN: begin
                if (cnt_reg == IDX_W'(DEPTH - 1)) begin
                    state_next = frct_pkg::FSM_FIN;
                end
            end
            frct_pkg::FSM_FIN: begin
                state_next = frct_pkg::FSM_OUT;
            end
            frct_pkg::FSM_OUT: begin
                if (out_free) begin
                    state_next = frct_pkg::FSM_IDLE;
                end
            end
            default: begin
                state_next = frct_pkg::FSM_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb begin
        ring       = '0;
        idle       = 1'b0;
        res_valid  = 1'b0;
        tail_addr  = head_addr;
        tail_count = head_count;
        case (state_reg)
            frct_pkg::FSM_IDLE: begin
                idle = 1'b1;
            end
            frct_pkg::FSM_SCAN: begin
                ring.shift = 1'b1;
                if (hit) begin
                    if (!action_reg) begin
                        tail_count = inc_count;
                    end else begin
                        tail_count = dec_count;
                        if (dec_count == '0) begin
                            tail_addr = '0;
                        end
                    end
                end
            end
            frct_pkg::FSM_FIN: begin
                ring.load  = (fin_status == frct_pkg::ST_INSERTED);
                tail_addr  = addr_reg;
                tail_count = frct_pkg::COUNT_W'(1);
            end
            frct_pkg::FSM_OUT: begin
                res_valid = out_free;
            end
            default: begin
                idle = 1'b0;
            end
        endcase
    end

    assign load_idx = empty_idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= frct_pkg::FSM_IDLE;
            cnt_reg        <= '0;
            found_reg      <= 1'b0;
            have_empty_reg <= 1'b0;
            empty_idx_reg  <= '0;
            status_reg     <= frct_pkg::ST_IGNORED;
            count_reg      <= '0;
            live_reg       <= '0;
            acq_reg        <= '0;
            rel_reg        <= '0;
            drop_reg       <= '0;
            untr_reg       <= '0;
            ins_reg        <= '0;
            peak_reg       <= '0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                frct_pkg::FSM_IDLE: begin
                    if (start) begin
                        cnt_reg        <= '0;
                        found_reg      <= 1'b0;
                        have_empty_reg <= 1'b0;
                    end
                end
                frct_pkg::FSM_SCAN: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (hit) begin
                        found_reg <= 1'b1;
                        if (!action_reg) begin
                            status_reg <= frct_pkg::ST_INCREMENTED;
                            count_reg  <= inc_count;
                        end else if (dec_count == '0) begin
                            status_reg <= frct_pkg::ST_FREED;
                            count_reg  <= '0;
                        end else begin
                            status_reg <= frct_pkg::ST_DECREMENTED;
                            count_reg  <= dec_count;
                        end
                    end
                    if (!have_empty_reg && head_addr == '0) begin
                        have_empty_reg <= 1'b1;
                        empty_idx_reg  <= cnt_reg;
                    end
                end
                frct_pkg::FSM_FIN: begin
                    status_reg <= fin_status;
                    count_reg  <= fin_count;
                    case (fin_status)
                        frct_pkg::ST_INCREMENTED: begin
                            acq_reg <= acq_reg + 1'b1;
                        end
                        frct_pkg::ST_INSERTED: begin
                            acq_reg  <= acq_reg + 1'b1;
                            ins_reg  <= ins_reg + 1'b1;
                            live_reg <= live_reg + 1'b1;
                        end
                        frct_pkg::ST_DROPPED: begin
                            drop_reg <= drop_reg + 1'b1;
                        end
                        frct_pkg::ST_DECREMENTED: begin
                            rel_reg <= rel_reg + 1'b1;
                        end
                        frct_pkg::ST_FREED: begin
                            rel_reg <= rel_reg + 1'b1;
                            if (live_reg != '0) begin
                                live_reg <= live_reg - 1'b1;
                            end
                        end
                        frct_pkg::ST_UNTRACKED: begin
                            untr_reg <= untr_reg + 1'b1;
                        end
                        default: begin
                            acq_reg <= acq_reg;
                        end
                    endcase
                    if ((fin_status == frct_pkg::ST_INCREMENTED ||
                         fin_status == frct_pkg::ST_INSERTED) && fin_count > peak_reg) begin
                        peak_reg <= fin_count;
                    end
                end
                default: begin
                    cnt_reg <= cnt_reg;
                end
            endcase
        end
    end

    // Request payload needs no reset.
    always_ff @(posedge aclk) begin
        if (state_reg == frct_pkg::FSM_IDLE && start) begin
            action_reg <= req_action;
            addr_reg   <= req_addr;
        end
    end

    assign live_ext = {{frct_pkg::LIVE_W{1'b0}}, live_reg};

    always_comb begin
        res.status      = status_reg;
        res.count_after = count_reg;
        res.live        = live_ext[frct_pkg::LIVE_W-1:0];
        res.acquires    = acq_reg;
        res.releases    = rel_reg;
        res.drops       = drop_reg;
        res.untracked   = untr_reg;
        res.inserts     = ins_reg;
        res.max_count   = {{(frct_pkg::STAT_W-frct_pkg::COUNT_W){1'b0}}, peak_reg};
    end

    a_load_only_unmatched: assert property (@(posedge aclk) disable iff (!aresetn)
        ring.load |-> (!found_reg && !action_reg && have_empty_reg))
        else $error("slot insert while the address was already in the table");

    a_zero_never_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == frct_pkg::FSM_FIN && addr_reg == '0) |-> !ring.load)
        else $error("zero address caused a slot write");

    a_live_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        live_reg <= LCNT_W'(DEPTH))
        else $error("live entry count beyond table depth");

    a_fin_then_out: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == frct_pkg::FSM_FIN |=> state_reg == frct_pkg::FSM_OUT)
        else $error("finish step not followed by result step");

endmodule

// File: src/frame_refcount_table_top.sv
// Top level of the frame reference-count table: slot ring, controller, output register.
`timescale 1ns / 1ps

// Channel | Direction | Beat contents
// s_      | in        | tdata: action[0], page_address[ADDR_W:1]
// m_      | out       | tdata: status, count_after, live_entries, five 32-bit counters,
//         |           |        max_count_seen
//
// An item with a nonzero address passes through a scan, in which the slot ring rotates
// once past the controller, then a finish step that applies the update, then a result
// step that loads the result register once it is free. A zero address skips the scan.
// Reset clears every slot and counter at once; no clearing pass is needed.
// A stalled result holds in the output register; a new item is taken only once the
// previous result has been moved to that register.

module frame_refcount_table_top #(
    parameter int TABLE_DEPTH  = frct_pkg::DEF_DEPTH,
    parameter int ADDRESS_BITS = frct_pkg::DEF_ADDR_W,
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    localparam int S_TDATA_W   = ((ADDRESS_BITS + 1 + 7) / 8) * 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // action [0], page_address [ADDRESS_BITS:1], zero fill above
    input  logic [S_TDATA_W-1:0]           s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // status [2:0], count_after [18:3], live_entries [25:19], acquires_total [57:26],
    // releases_total [89:58], full_drops [121:90], untracked_releases [153:122],
    // unique_inserts [185:154], max_count_seen [201:186], zero fill above
    output logic [frct_pkg::M_TDATA_W-1:0] m_tdata
);

    logic [ADDRESS_BITS-1:0]      cell_addr  [TABLE_DEPTH];
    logic [frct_pkg::COUNT_W-1:0] cell_count [TABLE_DEPTH];

    frct_pkg::ring_ctrl_t         ring;
    logic [IDX_W-1:0]             load_idx;
    logic [ADDRESS_BITS-1:0]      tail_addr;
    logic [frct_pkg::COUNT_W-1:0] tail_count;
    logic                         idle;
    logic                         res_valid;
    frct_pkg::result_t            res;
    logic                         start;
    logic                         out_free;

    logic                         m_tvalid_reg, m_tvalid_next;
    logic [frct_pkg::M_TDATA_W-1:0] m_tdata_reg;

    assign s_tready = idle;
    assign start    = s_tvalid && idle;
    assign out_free = !m_tvalid_reg || m_tready;

    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        logic [ADDRESS_BITS-1:0]      nxt_addr;
        logic [frct_pkg::COUNT_W-1:0] nxt_count;

        if (i == TABLE_DEPTH - 1) begin : g_tail
            assign nxt_addr  = tail_addr;
            assign nxt_count = tail_count;
        end else begin : g_mid
            assign nxt_addr  = cell_addr[i+1];
            assign nxt_count = cell_count[i+1];
        end

        frct_cell #(
            .ADDR_W (ADDRESS_BITS),
            .IDX_W  (IDX_W),
            .INDEX  (i)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (ring),
            .load_idx   (load_idx),
            .nxt_addr   (nxt_addr),
            .nxt_count  (nxt_count),
            .load_addr  (tail_addr),
            .load_count (tail_count),
            .addr       (cell_addr[i]),
            .count      (cell_count[i])
        );
    end

    frct_ctrl #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (ADDRESS_BITS),
        .IDX_W  (IDX_W)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (start),
        .req_action (s_tdata[0]),
        .req_addr   (s_tdata[ADDRESS_BITS:1]),
        .out_free   (out_free),
        .head_addr  (cell_addr[0]),
        .head_count (cell_count[0]),
        .ring       (ring),
        .load_idx   (load_idx),
        .tail_addr  (tail_addr),
        .tail_count (tail_count),
        .idle       (idle),
        .res_valid  (res_valid),
        .res        (res)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (res_valid) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_tdata_reg <= {6'd0,
                            res.max_count[frct_pkg::COUNT_W-1:0],
                            res.inserts,
                            res.untracked,
                            res.drops,
                            res.releases,
                            res.acquires,
                            res.live,
                            res.count_after,
                            res.status};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the frame reference-count table: page traffic in, checked results out.
`timescale 1ns / 1ps

module tb_top;

    localparam int DEPTH          = frct_pkg::DEF_DEPTH;
    localparam int ADDR_W         = frct_pkg::DEF_ADDR_W;
    localparam int S_TDATA_W      = ((ADDR_W + 1 + 7) / 8) * 8;
    localparam int POOL_SIZE      = 96;
    localparam int RANDOM_ITEMS   = 1900;
    localparam int WATCHDOG_LIMIT = 4000;

    localparam bit ACT_ACQUIRE = 1'b0;
    localparam bit ACT_RELEASE = 1'b1;

    typedef struct {
        bit                act;
        logic [ADDR_W-1:0] page;
        bit                hold;   // wait until every outstanding result is back
    } page_op_t;

    typedef struct {
        frct_pkg::status_t            status;
        logic [frct_pkg::COUNT_W-1:0] count_after;
        logic [frct_pkg::LIVE_W-1:0]  live;
        logic [frct_pkg::STAT_W-1:0]  acquires;
        logic [frct_pkg::STAT_W-1:0]  releases;
        logic [frct_pkg::STAT_W-1:0]  drops;
        logic [frct_pkg::STAT_W-1:0]  untracked;
        logic [frct_pkg::STAT_W-1:0]  inserts;
        logic [frct_pkg::COUNT_W-1:0] peak;
    } page_verdict_t;

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [S_TDATA_W-1:0]           s_tdata  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [frct_pkg::M_TDATA_W-1:0] m_tdata;

    // Shadow copy of the table and its statistics.
    logic [ADDR_W-1:0]            tbl_page [DEPTH];
    logic [frct_pkg::COUNT_W-1:0] tbl_count [DEPTH];
    logic [31:0]                  live_slots;
    logic [frct_pkg::STAT_W-1:0]  acquired_total;
    logic [frct_pkg::STAT_W-1:0]  released_total;
    logic [frct_pkg::STAT_W-1:0]  dropped_total;
    logic [frct_pkg::STAT_W-1:0]  untracked_total;
    logic [frct_pkg::STAT_W-1:0]  inserted_total;
    logic [frct_pkg::COUNT_W-1:0] peak_seen;

    page_op_t      pending_ops[$];
    page_verdict_t expected_verdicts[$];
    page_verdict_t want;
    page_verdict_t got;
    page_op_t      next_op;

    logic [ADDR_W-1:0] page_pool [POOL_SIZE];

    bit s_fire       = 1'b0;
    int items_taken  = 0;
    int items_queued = 0;
    int idle_cycles  = 0;
    int mismatches   = 0;
    int tx_idle_pct  = 29;
    int rx_stall_pct = 72;

    frame_refcount_table_top #(
        .TABLE_DEPTH  (DEPTH),
        .ADDRESS_BITS (ADDR_W)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic page_verdict_t apply_page_op(bit act, logic [ADDR_W-1:0] page);
        page_verdict_t v;
        int            hit;
        int            free_slot;
        int            i;
        v.status      = frct_pkg::ST_IGNORED;
        v.count_after = '0;
        if (page != '0) begin
            hit       = -1;
            free_slot = -1;
            for (i = 0; i < DEPTH; i++) begin
                if (hit < 0 && tbl_page[i] == page) hit = i;
                if (free_slot < 0 && tbl_page[i] == '0) free_slot = i;
            end
            if (act == ACT_ACQUIRE) begin
                if (hit >= 0) begin
                    if (tbl_count[hit] != frct_pkg::COUNT_MAX)
                        tbl_count[hit] = tbl_count[hit] + 1'b1;
                    if (tbl_count[hit] > peak_seen) peak_seen = tbl_count[hit];
                    acquired_total = acquired_total + 1'b1;
                    v.status       = frct_pkg::ST_INCREMENTED;
                    v.count_after  = tbl_count[hit];
                end else if (free_slot >= 0) begin
                    tbl_page[free_slot]  = page;
                    tbl_count[free_slot] = frct_pkg::COUNT_W'(1);
                    acquired_total       = acquired_total + 1'b1;
                    inserted_total       = inserted_total + 1'b1;
                    live_slots           = live_slots + 1'b1;
                    if (peak_seen == '0) peak_seen = frct_pkg::COUNT_W'(1);
                    v.status      = frct_pkg::ST_INSERTED;
                    v.count_after = frct_pkg::COUNT_W'(1);
                end else begin
                    dropped_total = dropped_total + 1'b1;
                    v.status      = frct_pkg::ST_DROPPED;
                end
            end else begin
                if (hit < 0) begin
                    untracked_total = untracked_total + 1'b1;
                    v.status        = frct_pkg::ST_UNTRACKED;
                end else begin
                    if (tbl_count[hit] != '0) tbl_count[hit] = tbl_count[hit] - 1'b1;
                    released_total = released_total + 1'b1;
                    if (tbl_count[hit] == '0) begin
                        tbl_page[hit] = '0;
                        if (live_slots != '0) live_slots = live_slots - 1'b1;
                        v.status = frct_pkg::ST_FREED;
                    end else begin
                        v.status      = frct_pkg::ST_DECREMENTED;
                        v.count_after = tbl_count[hit];
                    end
                end
            end
        end
        v.live      = live_slots[frct_pkg::LIVE_W-1:0];
        v.acquires  = acquired_total;
        v.releases  = released_total;
        v.drops     = dropped_total;
        v.untracked = untracked_total;
        v.inserts   = inserted_total;
        v.peak      = peak_seen;
        return v;
    endfunction

    task automatic check_field(string field, logic [31:0] want_v, logic [31:0] got_v);
        if (want_v !== got_v) begin
            mismatches++;
            $display("%0t ns: %s expected %0h, got %0h", $time, field, want_v, got_v);
        end
    endtask

    task automatic queue_op(bit act, logic [ADDR_W-1:0] page, bit hold);
        page_op_t op;
        op.act  = act;
        op.page = page;
        op.hold = hold;
        pending_ops.push_back(op);
    endtask

    // Result checking, accept tracking and the watchdog all sample at the rising edge.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_verdicts.size() == 0) begin
                mismatches++;
                $display("%0t ns: result beat expected none, got tdata %0h", $time, m_tdata);
            end else begin
                want = expected_verdicts.pop_front();
                got.status      = frct_pkg::status_t'(m_tdata[2:0]);
                got.count_after = m_tdata[18:3];
                got.live        = m_tdata[25:19];
                got.acquires    = m_tdata[57:26];
                got.releases    = m_tdata[89:58];
                got.drops       = m_tdata[121:90];
                got.untracked   = m_tdata[153:122];
                got.inserts     = m_tdata[185:154];
                got.peak        = m_tdata[201:186];
                check_field("status", 32'(want.status), 32'(got.status));
                check_field("count_after", 32'(want.count_after), 32'(got.count_after));
                check_field("live_entries", 32'(want.live), 32'(got.live));
                check_field("acquires_total", want.acquires, got.acquires);
                check_field("releases_total", want.releases, got.releases);
                check_field("full_drops", want.drops, got.drops);
                check_field("untracked_releases", want.untracked, got.untracked);
                check_field("unique_inserts", want.inserts, got.inserts);
                check_field("max_count_seen", 32'(want.peak), 32'(got.peak));
                check_field("tdata_fill", '0, 32'(m_tdata[frct_pkg::M_TDATA_W-1:202]));
            end
        end

        s_fire = aresetn && s_tvalid && s_tready;
        if (s_fire) begin
            expected_verdicts.push_back(apply_page_op(s_tdata[0], s_tdata[ADDR_W:1]));
            items_taken++;
            if (items_taken < items_queued / 3) begin
                tx_idle_pct  = 29;
                rx_stall_pct = 72;
            end else if (items_taken < 2 * items_queued / 3) begin
                tx_idle_pct  = 72;
                rx_stall_pct = 29;
            end else begin
                tx_idle_pct  = 0;
                rx_stall_pct = 0;
            end
        end

        if (!aresetn || s_fire || (m_tvalid && m_tready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("frame_refcount_table_top: mismatch");
            $finish;
        end
    end

    // Stimulus and backpressure change on the falling edge.
    always @(negedge aclk) begin
        if (aresetn) begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
            if (!s_tvalid || s_fire) begin
                if (pending_ops.size() == 0
                        || (pending_ops[0].hold && expected_verdicts.size() != 0)
                        || $urandom_range(99) < tx_idle_pct) begin
                    s_tvalid <= 1'b0;
                end else begin
                    next_op = pending_ops.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{(S_TDATA_W-ADDR_W-1){1'b0}}, next_op.page, next_op.act};
                end
            end
        end
    end

    initial begin
        logic [63:0]       raw;
        logic [ADDR_W-1:0] page;
        int                planned;
        int                mode;
        int                n;
        int                base;
        int                span;
        int                k;
        bit                hold;
        bit                act;

        for (int i = 0; i < DEPTH; i++) begin
            tbl_page[i]  = '0;
            tbl_count[i] = '0;
        end
        live_slots      = '0;
        acquired_total  = '0;
        released_total  = '0;
        dropped_total   = '0;
        untracked_total = '0;
        inserted_total  = '0;
        peak_seen       = '0;

        page_pool[0] = {ADDR_W{1'b1}};
        page_pool[1] = 48'h0000_0000_0001;
        page_pool[2] = 48'h8000_0000_0000;
        for (int i = 3; i < POOL_SIZE; i++) begin
            do begin
                raw  = {$urandom(), $urandom()};
                page = raw[ADDR_W-1:0];
            end while (page == '0);
            page_pool[i] = page;
        end

        // Directed: zero address both ways, unknown release, insert, bump, drain to free,
        // reuse of the lowest freed slot, and the address extremes.
        queue_op(ACT_ACQUIRE, '0, 1'b0);
        queue_op(ACT_RELEASE, '0, 1'b0);
        queue_op(ACT_RELEASE, {ADDR_W{1'b1}}, 1'b0);
        queue_op(ACT_ACQUIRE, {ADDR_W{1'b1}}, 1'b0);
        queue_op(ACT_ACQUIRE, {ADDR_W{1'b1}}, 1'b0);
        queue_op(ACT_ACQUIRE, 48'h0000_0000_0001, 1'b0);
        queue_op(ACT_ACQUIRE, 48'h8000_0000_0000, 1'b0);
        queue_op(ACT_RELEASE, {ADDR_W{1'b1}}, 1'b0);
        queue_op(ACT_RELEASE, {ADDR_W{1'b1}}, 1'b0);
        queue_op(ACT_ACQUIRE, 48'h5555_5555_5555, 1'b0);
        queue_op(ACT_RELEASE, 48'h0000_0000_0001, 1'b0);
        queue_op(ACT_RELEASE, 48'h0000_0000_0001, 1'b0);
        queue_op(ACT_ACQUIRE, 48'hAAAA_AAAA_AAAA, 1'b0);
        queue_op(ACT_ACQUIRE, 48'h0000_0000_0001, 1'b0);
        queue_op(ACT_RELEASE, 48'h5555_5555_5555, 1'b0);
        queue_op(ACT_RELEASE, 48'h8000_0000_0000, 1'b0);

        // A long run on one page builds a large count. Saturation at the count ceiling
        // would take 65535 acquires of one page and is out of reach in this run.
        planned = 0;
        page = page_pool[$urandom_range(POOL_SIZE-1)];
        for (int i = 0; i < 300; i++) begin
            queue_op(ACT_ACQUIRE, page, i == 0);
            planned++;
        end
        for (int i = 0; i < 20; i++) begin
            queue_op(ACT_RELEASE, page, 1'b0);
            planned++;
        end

        while (planned < RANDOM_ITEMS) begin
            mode = $urandom_range(9);
            hold = ($urandom_range(7) == 0);
            case (mode)
                0, 1, 2, 3: begin
                    // Churn over a small window of pages, so counts climb and fall.
                    n    = $urandom_range(60, 20);
                    base = $urandom_range(POOL_SIZE-1);
                    span = $urandom_range(24, 4);
                    for (int i = 0; i < n; i++) begin
                        act = ($urandom_range(99) < 55) ? ACT_ACQUIRE : ACT_RELEASE;
                        queue_op(act, page_pool[(base + $urandom_range(span-1)) % POOL_SIZE],
                                 hold && i == 0);
                        planned++;
                    end
                end
                4: begin
                    // Acquire many distinct pages to run the table into the full state.
                    base = $urandom_range(POOL_SIZE-1);
                    n    = $urandom_range(80, 50);
                    for (int i = 0; i < n; i++) begin
                        queue_op(ACT_ACQUIRE, page_pool[(base + i) % POOL_SIZE], hold && i == 0);
                        planned++;
                    end
                end
                5: begin
                    n = $urandom_range(120, 30);
                    for (int i = 0; i < n; i++) begin
                        queue_op(ACT_RELEASE, page_pool[$urandom_range(POOL_SIZE-1)],
                                 hold && i == 0);
                        planned++;
                    end
                end
                6: begin
                    page = page_pool[$urandom_range(POOL_SIZE-1)];
                    k    = $urandom_range(40, 5);
                    for (int i = 0; i < k; i++) begin
                        queue_op(ACT_ACQUIRE, page, hold && i == 0);
                        planned++;
                    end
                    n = $urandom_range(k + 2, 1);
                    for (int i = 0; i < n; i++) begin
                        queue_op(ACT_RELEASE, page, 1'b0);
                        planned++;
                    end
                end
                7: begin
                    // Unrelated addresses, including the null page.
                    n = $urandom_range(20, 5);
                    for (int i = 0; i < n; i++) begin
                        raw  = {$urandom(), $urandom()};
                        page = ($urandom_range(3) == 0) ? '0 : raw[ADDR_W-1:0];
                        queue_op(raw[63], page, hold && i == 0);
                        if (page != '0) planned++;
                    end
                end
                default: begin
                    n = $urandom_range(60, 20);
                    for (int i = 0; i < n; i++) begin
                        act = $urandom_range(1) ? ACT_RELEASE : ACT_ACQUIRE;
                        queue_op(act, page_pool[$urandom_range(POOL_SIZE-1)], hold && i == 0);
                        planned++;
                    end
                end
            endcase
        end
        items_queued = pending_ops.size();

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_ops.size() != 0 || s_tvalid || expected_verdicts.size() != 0)
            @(posedge aclk);
        repeat (DEPTH + 16) @(posedge aclk);

        if (mismatches == 0) begin
            $display("frame_refcount_table_top: match");
        end else begin
            $display("frame_refcount_table_top: mismatch");
        end
        $finish;
    end

endmodule
